// ----- design/jdc_pkg.sv -----
// ----------------------------------------------------------------------------
// jdc_pkg
// Shared widths, constants and tables for the Julian day to calendar pipeline.
// ----------------------------------------------------------------------------
package jdc_pkg;

	localparam int DAY_BITS      = 23;
	localparam int FRACTION_BITS = 32;
	localparam int PIPE_DEPTH    = 9;

	localparam int YEAR_W = 16;

	localparam int GREGORIAN_START = 2299161;

	// alpha = floor((4z - ALPHA_OFS) / ALPHA_DIV), exact reciprocal multiply
	localparam int ALPHA_OFS = 7468865;
	localparam int ALPHA_DIV = 146097;
	localparam int NA_W      = DAY_BITS + 2;
	localparam int ALPHA_K   = NA_W + 18;
	localparam int ALPHA_M_W = NA_W + 1;
	localparam int ALPHA_W   = NA_W - 17;
	localparam logic [ALPHA_M_W-1:0] ALPHA_M =
		ALPHA_M_W'(((64'd1 << ALPHA_K) + 64'(ALPHA_DIV) - 64'd1) / 64'(ALPHA_DIV));

	localparam int A_W = DAY_BITS + 1;

	// c = floor((20b - 2442) / C_DIV), b = a + B_OFS
	localparam int B_OFS  = 1524;
	localparam int NC_OFS = 20 * B_OFS - 2442;
	localparam int C_DIV  = 7305;
	localparam int NC_W   = DAY_BITS + 6;
	localparam int C_K    = NC_W + 13;
	localparam int C_M_W  = NC_W + 1;
	localparam int C_W    = NC_W - 12;
	localparam logic [C_M_W-1:0] C_M =
		C_M_W'(((64'd1 << C_K) + 64'(C_DIV) - 64'd1) / 64'(C_DIV));

	localparam int DAYS_4Y = 1461;

	localparam int YEAR_OFS_LATE  = 6616;
	localparam int YEAR_OFS_EARLY = 6615;
	localparam int C2_OFS_LATE    = 4717;
	localparam int C2_OFS_EARLY   = 4716;
	localparam int YDAY_BASE      = 1721424;

	// weekday: floor((z+1)/7) by exact reciprocal multiply
	localparam int W7_N   = DAY_BITS + 1;
	localparam int W7_K   = W7_N + 3;
	localparam int W7_M_W = W7_N + 1;
	localparam logic [W7_M_W-1:0] W7_M =
		W7_M_W'(((64'd1 << W7_K) + 64'd6) / 64'd7);

	// month length tables, 30.6001 as a ratio
	localparam int MONTH_NUM = 306001;
	localparam int MONTH_DEN = 10000;

	typedef logic [8:0] bd_tbl_t [16];

	function automatic bd_tbl_t make_e_floor();
		bd_tbl_t t;
		for (int i = 0; i < 16; i++) begin
			t[i] = 9'((MONTH_NUM * i) / MONTH_DEN);
		end
		return t;
	endfunction

	function automatic bd_tbl_t make_e_ceil();
		bd_tbl_t t;
		for (int i = 0; i < 16; i++) begin
			t[i] = 9'((MONTH_NUM * i + MONTH_DEN - 1) / MONTH_DEN);
		end
		return t;
	endfunction

	localparam bd_tbl_t E_FLOOR = make_e_floor();
	localparam bd_tbl_t E_CEIL  = make_e_ceil();

	typedef struct packed {
		logic signed [YEAR_W-1:0] year;
		logic [3:0]               mon;
		logic [4:0]               mday;
		logic [8:0]               yday;
	} date_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} clock_t;

endpackage

// ----- design/jdc_date.sv -----
// ----------------------------------------------------------------------------
// jdc_date
// Nine-stage Meeus date pipeline: day number to year, month, day, day of year.
// ----------------------------------------------------------------------------
module jdc_date (
	input  logic                          clk,
	input  logic [jdc_pkg::DAY_BITS-1:0]  z,
	output jdc_pkg::date_t                date
);

	logic [jdc_pkg::DAY_BITS-1:0]                 z_s1, z_s2;
	logic [jdc_pkg::NA_W-1:0]                     na_s1;
	logic                                         greg_s1, greg_s2;
	logic [jdc_pkg::NA_W+jdc_pkg::ALPHA_M_W-1:0]  aprod_s2;
	logic [jdc_pkg::A_W-1:0]                      a_s3;
	logic [jdc_pkg::NC_W-1:0]                     nc_s4;
	logic [jdc_pkg::NC_W+jdc_pkg::C_M_W-1:0]      cprod_s5;
	logic [8:0]                                   a9_s4, a9_s5, a9_s6, a9_s7, a9_s8;
	logic [8:0]                                   bd_s6, bd_s7;
	logic [jdc_pkg::YEAR_W-1:0]                   cy_s6, cy_s7;
	logic [3:0]                                   e_s7;
	logic [3:0]                                   mon_s8, mon_s9;
	logic [4:0]                                   mday_s8, mday_s9;
	logic [jdc_pkg::YEAR_W-1:0]                   year_s8, year_s9;
	logic [10:0]                                  p_s8;
	logic [8:0]                                   yday_s9;

	logic [jdc_pkg::ALPHA_W-1:0] alpha;
	logic [jdc_pkg::C_W-1:0]     c;
	logic [21:0]                 d4;
	logic [3:0]                  e;
	logic [3:0]                  mon;
	logic                        late;
	logic [10:0]                 c2;
	logic [21:0]                 p;

	assign alpha = aprod_s2[jdc_pkg::ALPHA_K +: jdc_pkg::ALPHA_W];
	assign c     = cprod_s5[jdc_pkg::C_K +: jdc_pkg::C_W];
	assign d4    = c[10:0] * 11'(jdc_pkg::DAYS_4Y);

	always_comb begin
		e = 4'd4;
		for (int k = 5; k < 16; k++) begin
			if (bd_s6 >= jdc_pkg::E_CEIL[k]) e = 4'(k);
		end
	end

	assign mon  = (e_s7 < 4'd14) ? e_s7 - 4'd2 : e_s7 - 4'd14;
	assign late = (mon > 4'd1);
	assign c2   = cy_s7[10:0] - (late ? 11'(jdc_pkg::C2_OFS_LATE) : 11'(jdc_pkg::C2_OFS_EARLY));
	assign p    = c2 * 11'(jdc_pkg::DAYS_4Y);

	always_ff @(posedge clk) begin
		// s1
		z_s1    <= z;
		na_s1   <= {z, 2'b00} - jdc_pkg::NA_W'(jdc_pkg::ALPHA_OFS);
		greg_s1 <= (z >= jdc_pkg::DAY_BITS'(jdc_pkg::GREGORIAN_START));
		// s2
		aprod_s2 <= na_s1 * jdc_pkg::ALPHA_M;
		z_s2     <= z_s1;
		greg_s2  <= greg_s1;
		// s3
		if (greg_s2) begin
			a_s3 <= jdc_pkg::A_W'(z_s2) + jdc_pkg::A_W'(1) + jdc_pkg::A_W'(alpha)
				- jdc_pkg::A_W'(alpha >> 2);
		end else begin
			a_s3 <= jdc_pkg::A_W'(z_s2);
		end
		// s4
		nc_s4 <= jdc_pkg::NC_W'({a_s3, 4'b0000}) + jdc_pkg::NC_W'({a_s3, 2'b00})
			+ jdc_pkg::NC_W'(jdc_pkg::NC_OFS);
		a9_s4 <= a_s3[8:0];
		// s5
		cprod_s5 <= nc_s4 * jdc_pkg::C_M;
		a9_s5    <= a9_s4;
		// s6: b - d, only the low bits matter
		bd_s6 <= a9_s5 + 9'(jdc_pkg::B_OFS) - d4[10:2];
		cy_s6 <= c[jdc_pkg::YEAR_W-1:0];
		a9_s6 <= a9_s5;
		// s7
		e_s7  <= e;
		bd_s7 <= bd_s6;
		cy_s7 <= cy_s6;
		a9_s7 <= a9_s6;
		// s8
		mon_s8  <= mon;
		mday_s8 <= 5'(bd_s7 - jdc_pkg::E_FLOOR[e_s7]);
		year_s8 <= cy_s7 - (late ? jdc_pkg::YEAR_W'(jdc_pkg::YEAR_OFS_LATE)
			: jdc_pkg::YEAR_W'(jdc_pkg::YEAR_OFS_EARLY));
		p_s8    <= p[10:0];
		a9_s8   <= a9_s7;
		// s9: day of year mod 512
		yday_s9 <= a9_s8 - p_s8[10:2] - 9'(jdc_pkg::YDAY_BASE);
		mon_s9  <= mon_s8;
		mday_s9 <= mday_s8;
		year_s9 <= year_s8;
	end

	assign date.year = $signed(year_s9);
	assign date.mon  = mon_s9;
	assign date.mday = mday_s9;
	assign date.yday = yday_s9;

endmodule

// ----- design/jdc_clock.sv -----
// ----------------------------------------------------------------------------
// jdc_clock
// Splits the day fraction into hour, minute, second; padded to pipe depth.
// ----------------------------------------------------------------------------
module jdc_clock (
	input  logic                              clk,
	input  logic [jdc_pkg::FRACTION_BITS-1:0] f,
	output jdc_pkg::clock_t                   hms
);

	localparam int FB  = jdc_pkg::FRACTION_BITS;
	localparam int PAD = jdc_pkg::PIPE_DEPTH - 3;

	logic [4:0]    hour_s1, hour_s2;
	logic [5:0]    minute_s2;
	logic [FB-1:0] rem_s1, rem_s2;
	jdc_pkg::clock_t hms_s3;
	jdc_pkg::clock_t pad_q [PAD];

	logic [FB+4:0] t1;
	logic [FB+5:0] t2, t3;

	assign t1 = (FB+5)'({f, 4'b0000}) + (FB+5)'({f, 3'b000});
	assign t2 = (FB+6)'({rem_s1, 6'b000000}) - (FB+6)'({rem_s1, 2'b00});
	assign t3 = (FB+6)'({rem_s2, 6'b000000}) - (FB+6)'({rem_s2, 2'b00});

	always_ff @(posedge clk) begin
		hour_s1   <= t1[FB+4:FB];
		rem_s1    <= t1[FB-1:0];
		hour_s2   <= hour_s1;
		minute_s2 <= t2[FB+5:FB];
		rem_s2    <= t2[FB-1:0];
		hms_s3.hour   <= hour_s2;
		hms_s3.minute <= minute_s2;
		hms_s3.second <= t3[FB+5:FB];
		pad_q[0] <= hms_s3;
		for (int i = 1; i < PAD; i++) begin
			pad_q[i] <= pad_q[i-1];
		end
	end

	assign hms = pad_q[PAD-1];

endmodule

// ----- design/jdc_weekday.sv -----
// ----------------------------------------------------------------------------
// jdc_weekday
// (z + 1) mod 7 by reciprocal multiply; padded to pipe depth.
// ----------------------------------------------------------------------------
module jdc_weekday (
	input  logic [jdc_pkg::DAY_BITS-1:0] z,
	input  logic                         clk,
	output logic [2:0]                   wday
);

	localparam int PAD = jdc_pkg::PIPE_DEPTH - 2;

	logic [jdc_pkg::W7_N-1:0]                  n;
	logic [jdc_pkg::W7_N+jdc_pkg::W7_M_W-1:0] prod_s1;
	logic [2:0]                                n3_s1;
	logic [2:0]                                wd_s2;
	logic [2:0]                                pad_q [PAD];

	assign n = jdc_pkg::W7_N'(z) + jdc_pkg::W7_N'(1);

	always_ff @(posedge clk) begin
		prod_s1 <= n * jdc_pkg::W7_M;
		n3_s1   <= n[2:0];
		// n - 7q == n + q (mod 8), and the remainder is below 7
		wd_s2   <= n3_s1 + prod_s1[jdc_pkg::W7_K +: 3];
		pad_q[0] <= wd_s2;
		for (int i = 1; i < PAD; i++) begin
			pad_q[i] <= pad_q[i-1];
		end
	end

	assign wday = pad_q[PAD-1];

endmodule

// ----- design/julian_day_to_calendar.sv -----
// ----------------------------------------------------------------------------
// julian_day_to_calendar
// Julian day number and day fraction to broken-down civil date and time.
// ----------------------------------------------------------------------------
// Usage:
//   Drive day_number and day_fraction and raise start for one cycle; the
//   transfer happens at that edge. busy is always low: a new item may be
//   started in every cycle.
//   The pipe depth is set by the date pipeline (alpha multiply, century
//   multiply, month search, day-of-year fixup). Throughput is one item per
//   cycle; every stage is a register stage with no feedback.
//   Each result appears for exactly one cycle with done high. Results come
//   out in start order. The receiver cannot stall and the pipeline never
//   holds.
//   Reset clears the valid pipeline, so done stays low until the first
//   started item reaches the end. Data registers are not reset.
// ----------------------------------------------------------------------------
module julian_day_to_calendar (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [jdc_pkg::DAY_BITS-1:0]      day_number,
	input  logic [jdc_pkg::FRACTION_BITS-1:0] day_fraction,
	output logic                              done,
	output logic signed [15:0]                year_since_1900,
	output logic [3:0]                        month_index,
	output logic [4:0]                        day_of_month,
	output logic [4:0]                        hour_of_day,
	output logic [5:0]                        minute_of_hour,
	output logic [5:0]                        second_of_minute,
	output logic [2:0]                        weekday,
	output logic [8:0]                        day_of_year
);

	logic [jdc_pkg::PIPE_DEPTH-1:0] valid_q;
	jdc_pkg::date_t                 date;
	jdc_pkg::clock_t                hms;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[jdc_pkg::PIPE_DEPTH-2:0], start & ~busy};
		end
	end

	jdc_date u_date (
		.clk  (clk),
		.z    (day_number),
		.date (date)
	);

	jdc_clock u_clock (
		.clk (clk),
		.f   (day_fraction),
		.hms (hms)
	);

	jdc_weekday u_weekday (
		.z    (day_number),
		.clk  (clk),
		.wday (weekday)
	);

	assign done             = valid_q[jdc_pkg::PIPE_DEPTH-1];
	assign year_since_1900  = date.year;
	assign month_index      = date.mon;
	assign day_of_month     = date.mday;
	assign day_of_year      = date.yday;
	assign hour_of_day      = hms.hour;
	assign minute_of_hour   = hms.minute;
	assign second_of_minute = hms.second;

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for the Julian day to civil calendar converter.
// Each started conversion is predicted by an exact integer version of Meeus'
// method and queued. Every done strobe is checked field by field against the
// oldest queued date. Directed dates cover the range ends, the Julian to
// Gregorian switch, leap days and second boundaries of the fraction. Random
// streams follow, with the sender idling sometimes, often, then never.
// ----------------------------------------------------------------------------
module tb;

	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 2 * jdc_pkg::PIPE_DEPTH + 4;

	typedef struct {
		logic signed [15:0] year;
		logic [3:0]         mon;
		logic [4:0]         mday;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
		logic [2:0]         wday;
		logic [8:0]         yday;
	} civil_date_t;

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic [jdc_pkg::DAY_BITS-1:0]      day_number = '0;
	logic [jdc_pkg::FRACTION_BITS-1:0] day_fraction = '0;
	logic                              busy;
	logic                              done;
	logic signed [15:0]                year_since_1900;
	logic [3:0]                        month_index;
	logic [4:0]                        day_of_month;
	logic [4:0]                        hour_of_day;
	logic [5:0]                        minute_of_hour;
	logic [5:0]                        second_of_minute;
	logic [2:0]                        weekday;
	logic [8:0]                        day_of_year;

	civil_date_t pending_dates[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          idle_pct = 0;

	julian_day_to_calendar dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.day_number       (day_number),
		.day_fraction     (day_fraction),
		.done             (done),
		.year_since_1900  (year_since_1900),
		.month_index      (month_index),
		.day_of_month     (day_of_month),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.weekday          (weekday),
		.day_of_year      (day_of_year)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint floor_quot(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic civil_date_t convert_jd(logic [jdc_pkg::DAY_BITS-1:0] dn,
			logic [jdc_pkg::FRACTION_BITS-1:0] fr);
		longint      z, a, alpha, b, c, d, e, mon, yr, yday;
		logic [63:0] t;
		civil_date_t r;
		z = longint'(dn);
		if (z < jdc_pkg::GREGORIAN_START) begin
			a = z;
		end else begin
			alpha = floor_quot(4 * z - 7468865, 146097);
			a = z + 1 + alpha - floor_quot(alpha, 4);
		end
		b = a + 1524;
		c = floor_quot(20 * b - 2442, 7305);
		d = floor_quot(1461 * c, 4);
		e = floor_quot(10000 * (b - d), 306001);
		mon = (e < 14) ? e - 2 : e - 14;
		yr = (mon > 1) ? c - 6616 : c - 6615;
		yday = a - floor_quot(1461 * (yr + 1900 - 1), 4) - 1721424;
		r.year = yr[15:0];
		r.mon = mon[3:0];
		r.mday = 5'(b - d - floor_quot(306001 * e, 10000));
		t = 64'(fr) * 64'd24;
		r.hour = 5'(t >> jdc_pkg::FRACTION_BITS);
		t = (t & 64'hFFFF_FFFF) * 64'd60;
		r.minute = 6'(t >> jdc_pkg::FRACTION_BITS);
		t = (t & 64'hFFFF_FFFF) * 64'd60;
		r.second = 6'(t >> jdc_pkg::FRACTION_BITS);
		r.wday = 3'((z + 1) % 7);
		r.yday = yday[8:0];
		return r;
	endfunction

	// smallest fraction that reaches the given second of the day
	function automatic logic [31:0] second_edge(int unsigned s);
		longint q;
		q = ((longint'(s) << 32) + 86399) / 86400;
		return q[31:0];
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t, result %0d: %s", $time, results_seen, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		civil_date_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_dates.size() == 0) begin
				report_mismatch("result with no transfer outstanding");
			end else begin
				want = pending_dates.pop_front();
				if (year_since_1900 !== want.year)
					report_mismatch($sformatf("year %0d, expected %0d", year_since_1900,
						want.year));
				if (month_index !== want.mon)
					report_mismatch($sformatf("month %0d, expected %0d", month_index, want.mon));
				if (day_of_month !== want.mday)
					report_mismatch($sformatf("mday %0d, expected %0d", day_of_month, want.mday));
				if (hour_of_day !== want.hour)
					report_mismatch($sformatf("hour %0d, expected %0d", hour_of_day, want.hour));
				if (minute_of_hour !== want.minute)
					report_mismatch($sformatf("minute %0d, expected %0d", minute_of_hour,
						want.minute));
				if (second_of_minute !== want.second)
					report_mismatch($sformatf("second %0d, expected %0d", second_of_minute,
						want.second));
				if (weekday !== want.wday)
					report_mismatch($sformatf("weekday %0d, expected %0d", weekday, want.wday));
				if (day_of_year !== want.yday)
					report_mismatch($sformatf("yday %0d, expected %0d", day_of_year, want.yday));
			end
			results_seen++;
		end
		if (arst_n && start && !busy)
			pending_dates.push_back(convert_jd(day_number, day_fraction));
	end

	initial begin
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done === 1'b1)
				stalled = 0;
			else
				stalled++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_timestamp(logic [jdc_pkg::DAY_BITS-1:0] dn,
			logic [jdc_pkg::FRACTION_BITS-1:0] fr);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		day_number <= dn;
		day_fraction <= fr;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic do_reset();
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	task automatic test_dates_directed();
		send_timestamp('0, '0);
		send_timestamp('1, '1);
		send_timestamp(23'd2299160, 32'h0000_0000);
		send_timestamp(23'd2299161, 32'h8000_0000);
		send_timestamp(23'd2451545, 32'h8000_0000);
		send_timestamp(23'd2451604, 32'h4000_0000);
		send_timestamp(23'd2451910, 32'hC000_0000);
		send_timestamp(23'd2451605, 32'h1234_5678);
		send_timestamp(23'd1721424, 32'h0000_0001);
		send_timestamp(23'd1721423, 32'hFFFF_FFFE);
		send_timestamp(23'd1721058, 32'h0000_0000);
		send_timestamp(23'd1000000, 32'h5555_5555);
		send_timestamp(23'h2AAAAA, 32'hAAAA_AAAA);
		send_timestamp(23'h555555, 32'h5555_5555);
	endtask

	task automatic test_fraction_directed();
		send_timestamp(23'd2460000, second_edge(1));
		send_timestamp(23'd2460001, second_edge(1) - 1);
		send_timestamp(23'd2460002, second_edge(60));
		send_timestamp(23'd2460003, second_edge(3600) - 1);
		send_timestamp(23'd2460004, second_edge(3600));
		send_timestamp(23'd2460005, second_edge(86399) - 1);
		send_timestamp(23'd2460006, second_edge(86399));
		send_timestamp(23'd2460007, 32'hFFFF_FFFF);
	endtask

	task automatic test_random_stream(int count, int pct);
		logic [jdc_pkg::DAY_BITS-1:0]      dn;
		logic [jdc_pkg::FRACTION_BITS-1:0] fr;
		int unsigned                       s;
		idle_pct = pct;
		repeat (count) begin
			case ($urandom_range(0, 3))
				0: dn = jdc_pkg::DAY_BITS'($urandom_range(0, (1 << jdc_pkg::DAY_BITS) - 1));
				1: dn = jdc_pkg::DAY_BITS'($urandom_range(2400000, 2500000));
				2: dn = jdc_pkg::DAY_BITS'($urandom_range(jdc_pkg::GREGORIAN_START - 800,
					jdc_pkg::GREGORIAN_START + 800));
				default: dn = jdc_pkg::DAY_BITS'($urandom_range(0, 1) ? $urandom_range(0, 1500)
					: $urandom_range((1 << jdc_pkg::DAY_BITS) - 1500,
					(1 << jdc_pkg::DAY_BITS) - 1));
			endcase
			case ($urandom_range(0, 2))
				0: fr = $urandom;
				1: begin
					s = $urandom_range(1, 86399);
					fr = second_edge(s) - $urandom_range(0, 1);
				end
				default: fr = $urandom_range(0, 1) ? $urandom_range(0, 15) : ~32'($urandom_range(0, 15));
			endcase
			send_timestamp(dn, fr);
		end
	endtask

	initial begin
		do_reset();
		idle_pct = 37;
		test_dates_directed();
		test_fraction_directed();
		test_random_stream(250, 37);
		test_random_stream(250, 58);
		test_random_stream(250, 0);
		start <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- julian_day_to_calendar.f -----
design/jdc_pkg.sv
design/jdc_date.sv
design/jdc_clock.sv
design/jdc_weekday.sv
design/julian_day_to_calendar.sv
dv/tb.sv
